/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros used by ddft_ctrl.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define DDFT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define DDFT_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

/* design/ddft_pkg.sv */
// ----------------------------------------------------------------------------
// ddft_pkg
// Types, constants and twiddle rounding for the direct real-input DFT.
// ----------------------------------------------------------------------------
package ddft_pkg;

  // Default transform length and fixed field widths
  localparam int POINTS_DEF = 64;
  localparam int SAMPLE_W   = 16;
  localparam int TW_W       = 16;
  localparam int PROD_W     = SAMPLE_W + TW_W;
  localparam int ACC_W      = 40;
  localparam int BIN_W      = 6;
  localparam int OUT_W      = 23;
  localparam int RND_SHIFT  = 15;
  localparam int TAYLOR_N   = 26;

  // pi in Q32 and the Q28 rounding helpers
  localparam longint unsigned PI_Q32 = 64'd13493037705;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN,
    ST_SEND
  } state_t;

  // Tag that travels with each multiply-accumulate request
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_tag_t;

  // Round a Q28 value to Q15, half up, saturated to 16 bits
  function automatic logic signed [TW_W-1:0] q28_to_q15(input longint v);
    longint          t;
    longint unsigned tu;
    longint          r;
    t  = v + (longint'(1) <<< 31) + longint'(4096);
    tu = longint'(t);
    tu = tu >> 13;
    r  = longint'(tu) - (longint'(1) <<< 18);
    if (r > longint'(32767)) r = longint'(32767);
    if (r < -longint'(32768)) r = -longint'(32768);
    return TW_W'(r);
  endfunction

endpackage

/* design/ddft_sample_mem.sv */
// ----------------------------------------------------------------------------
// ddft_sample_mem
// Sample store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ddft_sample_mem #(
  parameter int POINTS = ddft_pkg::POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(POINTS)-1:0]           wr_addr,
  input  logic signed [ddft_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [$clog2(POINTS)-1:0]           rd_addr,
  output logic signed [ddft_pkg::SAMPLE_W-1:0] rd_data
);

  logic signed [ddft_pkg::SAMPLE_W-1:0] mem [POINTS];
  logic signed [ddft_pkg::SAMPLE_W-1:0] rd_data_r;

  // Store incoming samples
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one sample per cycle
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* design/ddft_twiddle_rom.sv */
// ----------------------------------------------------------------------------
// ddft_twiddle_rom
// Constant cosine/sine table of POINTS entries with a registered read.
// ----------------------------------------------------------------------------
module ddft_twiddle_rom #(
  parameter int POINTS = ddft_pkg::POINTS_DEF
) (
  input  logic                            clk,
  input  logic [$clog2(POINTS)-1:0]       tw_idx,
  output logic signed [ddft_pkg::TW_W-1:0] tw_cos,
  output logic signed [ddft_pkg::TW_W-1:0] tw_sin
);

  logic signed [ddft_pkg::TW_W-1:0] cos_tab [POINTS];
  logic signed [ddft_pkg::TW_W-1:0] sin_tab [POINTS];
  logic signed [ddft_pkg::TW_W-1:0] tw_cos_r;
  logic signed [ddft_pkg::TW_W-1:0] tw_sin_r;

  // Build the table at elaboration; angles above pi fold back with sine negated
  for (genvar m = 0; m < POINTS; m++) begin : g_tab
    localparam bit              FLIP = (2 * m > POINTS);
    localparam longint unsigned MM   = FLIP ? longint'(POINTS - m) : longint'(m);
    localparam longint unsigned X    =
      ((2 * ddft_pkg::PI_Q32 * MM) / longint'(POINTS) + 64'd8) >> 4;
    // Taylor terms x^n / n! in Q28, each derived from the one before
    localparam longint unsigned T0  = 64'd1 << 28;
    localparam longint unsigned T1  = (T0 * X) >> 28;
    localparam longint unsigned T2  = ((T1 * X) >> 28) / 64'd2;
    localparam longint unsigned T3  = ((T2 * X) >> 28) / 64'd3;
    localparam longint unsigned T4  = ((T3 * X) >> 28) / 64'd4;
    localparam longint unsigned T5  = ((T4 * X) >> 28) / 64'd5;
    localparam longint unsigned T6  = ((T5 * X) >> 28) / 64'd6;
    localparam longint unsigned T7  = ((T6 * X) >> 28) / 64'd7;
    localparam longint unsigned T8  = ((T7 * X) >> 28) / 64'd8;
    localparam longint unsigned T9  = ((T8 * X) >> 28) / 64'd9;
    localparam longint unsigned T10 = ((T9 * X) >> 28) / 64'd10;
    localparam longint unsigned T11 = ((T10 * X) >> 28) / 64'd11;
    localparam longint unsigned T12 = ((T11 * X) >> 28) / 64'd12;
    localparam longint unsigned T13 = ((T12 * X) >> 28) / 64'd13;
    localparam longint unsigned T14 = ((T13 * X) >> 28) / 64'd14;
    localparam longint unsigned T15 = ((T14 * X) >> 28) / 64'd15;
    localparam longint unsigned T16 = ((T15 * X) >> 28) / 64'd16;
    localparam longint unsigned T17 = ((T16 * X) >> 28) / 64'd17;
    localparam longint unsigned T18 = ((T17 * X) >> 28) / 64'd18;
    localparam longint unsigned T19 = ((T18 * X) >> 28) / 64'd19;
    localparam longint unsigned T20 = ((T19 * X) >> 28) / 64'd20;
    localparam longint unsigned T21 = ((T20 * X) >> 28) / 64'd21;
    localparam longint unsigned T22 = ((T21 * X) >> 28) / 64'd22;
    localparam longint unsigned T23 = ((T22 * X) >> 28) / 64'd23;
    localparam longint unsigned T24 = ((T23 * X) >> 28) / 64'd24;
    localparam longint unsigned T25 = ((T24 * X) >> 28) / 64'd25;
    localparam longint unsigned T26 = ((T25 * X) >> 28) / 64'd26;
    // Even terms sum to the cosine, odd terms to the sine, with alternating signs
    localparam longint C_SUM =
      longint'(T0) - longint'(T2) + longint'(T4) - longint'(T6) +
      longint'(T8) - longint'(T10) + longint'(T12) - longint'(T14) +
      longint'(T16) - longint'(T18) + longint'(T20) - longint'(T22) +
      longint'(T24) - longint'(T26);
    localparam longint S_RAW =
      longint'(T1) - longint'(T3) + longint'(T5) - longint'(T7) +
      longint'(T9) - longint'(T11) + longint'(T13) - longint'(T15) +
      longint'(T17) - longint'(T19) + longint'(T21) - longint'(T23) +
      longint'(T25);
    localparam longint S_SUM = FLIP ? -S_RAW : S_RAW;
    assign cos_tab[m] = ddft_pkg::q28_to_q15(C_SUM);
    assign sin_tab[m] = ddft_pkg::q28_to_q15(S_SUM);
  end

  // Register the selected twiddle pair
  always_ff @(posedge clk) begin
    tw_cos_r <= cos_tab[tw_idx];
    tw_sin_r <= sin_tab[tw_idx];
  end

  assign tw_cos = tw_cos_r;
  assign tw_sin = tw_sin_r;

endmodule

/* design/ddft_mac.sv */
// ----------------------------------------------------------------------------
// ddft_mac
// Shared complex multiply-accumulate unit: real sample times twiddle pair.
// ----------------------------------------------------------------------------
module ddft_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ddft_pkg::mac_tag_t                tag_in,
  input  logic signed [ddft_pkg::SAMPLE_W-1:0] smp,
  input  logic signed [ddft_pkg::TW_W-1:0]  tw_cos,
  input  logic signed [ddft_pkg::TW_W-1:0]  tw_sin,
  output logic signed [ddft_pkg::ACC_W-1:0] acc_re,
  output logic signed [ddft_pkg::ACC_W-1:0] acc_im,
  output logic                              done
);

  ddft_pkg::mac_tag_t                  tag1_r;
  ddft_pkg::mac_tag_t                  tag2_r;
  logic signed [ddft_pkg::PROD_W-1:0]  prod_c_r;
  logic signed [ddft_pkg::PROD_W-1:0]  prod_s_r;
  logic signed [ddft_pkg::ACC_W-1:0]   acc_re_r;
  logic signed [ddft_pkg::ACC_W-1:0]   acc_im_r;
  logic signed [ddft_pkg::ACC_W-1:0]   acc_re_nxt;
  logic signed [ddft_pkg::ACC_W-1:0]   acc_im_nxt;
  logic signed [ddft_pkg::ACC_W-1:0]   ext_c;
  logic signed [ddft_pkg::ACC_W-1:0]   ext_s;
  logic                                done_r;

  // Advance the request tags alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      done_r <= 1'b0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      done_r <= tag2_r.valid && tag2_r.last;
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    prod_c_r <= smp * tw_cos;
    prod_s_r <= smp * tw_sin;
  end

  // Accumulate: restart on the first term of a bin, subtract for the imaginary part
  assign ext_c = ddft_pkg::ACC_W'(prod_c_r);
  assign ext_s = ddft_pkg::ACC_W'(prod_s_r);

  always_comb begin
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    if (tag2_r.valid) begin
      if (tag2_r.first) begin
        acc_re_nxt = ext_c;
        acc_im_nxt = -ext_s;
      end else begin
        acc_re_nxt = acc_re_r + ext_c;
        acc_im_nxt = acc_im_r - ext_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_re_r <= acc_re_nxt;
    acc_im_r <= acc_im_nxt;
  end

  assign acc_re = acc_re_r;
  assign acc_im = acc_im_r;
  assign done   = done_r;

endmodule

/* design/ddft_ctrl.sv */
// ----------------------------------------------------------------------------
// ddft_ctrl
// Sequencer: loads samples, issues MAC requests per bin, hands out results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ddft_ctrl #(
  parameter int POINTS = ddft_pkg::POINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic                         mem_we,
  output logic [$clog2(POINTS)-1:0]    mem_wr_addr,
  output logic [$clog2(POINTS)-1:0]    mem_rd_addr,
  output logic [$clog2(POINTS)-1:0]    tw_idx,
  output ddft_pkg::mac_tag_t           mac_tag,
  input  logic                         mac_done,
  output logic [$clog2(POINTS)-1:0]    bin_k,
  output logic                         last_bin
);

  localparam int IDX_W = $clog2(POINTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

  ddft_pkg::state_t  state_r, state_nxt;
  logic [IDX_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic [IDX_W-1:0]  n_r, n_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W:0]    idx_sum;
  logic [IDX_W-1:0]  idx_wrap;

  // Twiddle index (k*n) mod POINTS, advanced by k each step
  assign idx_sum  = {1'b0, idx_r} + {1'b0, k_r};
  assign idx_wrap = (idx_sum >= (IDX_W + 1)'(POINTS)) ?
                    IDX_W'(idx_sum - (IDX_W + 1)'(POINTS)) : IDX_W'(idx_sum);

  // Next state and counters
  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    n_nxt        = n_r;
    k_nxt        = k_r;
    idx_nxt      = idx_r;
    case (state_r)
      ddft_pkg::ST_LOAD: begin
        if (in_valid) begin
          if (load_cnt_r == LAST_IDX) begin
            load_cnt_nxt = '0;
            n_nxt        = '0;
            k_nxt        = '0;
            idx_nxt      = '0;
            state_nxt    = ddft_pkg::ST_ISSUE;
          end else begin
            load_cnt_nxt = load_cnt_r + 1'b1;
          end
        end
      end
      ddft_pkg::ST_ISSUE: begin
        if (n_r == LAST_IDX) begin
          n_nxt     = '0;
          idx_nxt   = '0;
          state_nxt = ddft_pkg::ST_DRAIN;
        end else begin
          n_nxt   = n_r + 1'b1;
          idx_nxt = idx_wrap;
        end
      end
      ddft_pkg::ST_DRAIN: begin
        if (mac_done) begin
          state_nxt = ddft_pkg::ST_SEND;
        end
      end
      ddft_pkg::ST_SEND: begin
        if (!out_stall) begin
          if (k_r == LAST_IDX) begin
            state_nxt = ddft_pkg::ST_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ddft_pkg::ST_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = ddft_pkg::ST_LOAD;
      end
    endcase
  end

  // Outputs decoded from the state
  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    mem_we        = 1'b0;
    mac_tag.valid = 1'b0;
    mac_tag.first = (n_r == '0);
    mac_tag.last  = (n_r == LAST_IDX);
    case (state_r)
      ddft_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        mem_we   = in_valid;
      end
      ddft_pkg::ST_ISSUE: begin
        mac_tag.valid = 1'b1;
      end
      ddft_pkg::ST_SEND: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign mem_wr_addr = load_cnt_r;
  assign mem_rd_addr = n_r;
  assign tw_idx      = idx_r;
  assign bin_k       = k_r;
  assign last_bin    = (k_r == LAST_IDX);

  // State and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ddft_pkg::ST_LOAD;
      load_cnt_r <= '0;
      n_r        <= '0;
      k_r        <= '0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      n_r        <= n_nxt;
      k_r        <= k_nxt;
      idx_r      <= idx_nxt;
    end
  end

  // Never take a sample and present a result in the same cycle
  `DDFT_ASSERT(a_sides_exclusive, clk, rst_n, !(!in_stall && out_valid), "input and output open together")
  // The MAC finishes a bin only while the sequencer waits for it
  `DDFT_ASSERT(a_done_in_drain, clk, rst_n, !mac_done || (state_r == ddft_pkg::ST_DRAIN), "MAC done outside drain")
  // Delivering the final bin returns to loading with an empty block
  `DDFT_ASSERT_NEXT(a_last_to_load, clk, rst_n, out_valid && !out_stall && last_bin, (state_r == ddft_pkg::ST_LOAD) && (load_cnt_r == '0), "final bin did not restart loading")

endmodule

/* design/direct_dft_real_input_top.sv */
// ----------------------------------------------------------------------------
// direct_dft_real_input_top
// Direct DFT of a block of POINTS real Q1.15 samples, one complex MAC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_sample) takes one sample per
//   request. After POINTS samples the block computes every bin
//   X[k] = sum x[n]*exp(-j*2*pi*k*n/POINTS) and stalls its input.
//   Output channel (out_valid / out_stall / out_bin_*) gives POINTS requests
//   in bin order; out_last_bin marks bin POINTS-1. Real and imaginary parts
//   are the full-precision sums shifted right by 15 with rounding.
// Sequence: loading stores one sample per request. Each bin then issues
//   POINTS products to the one complex MAC, waits while the last product
//   passes the read, multiply and accumulate stages, and then presents the
//   result. The input stays stalled until the final bin of the block has
//   been taken.
// Reset (rst_n, synchronous) empties the block and returns to loading.
// A stalled result holds; the next bin does not start until it is taken.
// ----------------------------------------------------------------------------
module direct_dft_real_input_top #(
  parameter int POINTS = ddft_pkg::POINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [ddft_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ddft_pkg::BIN_W-1:0]           out_bin_index,
  output logic signed [ddft_pkg::OUT_W-1:0]    out_bin_real,
  output logic signed [ddft_pkg::OUT_W-1:0]    out_bin_imag,
  output logic                                 out_last_bin
);

  localparam int IDX_W = $clog2(POINTS);
  localparam logic signed [ddft_pkg::ACC_W-1:0] RND_HALF =
    ddft_pkg::ACC_W'(1) <<< (ddft_pkg::RND_SHIFT - 1);

  logic                                 mem_we;
  logic [IDX_W-1:0]                     mem_wr_addr;
  logic [IDX_W-1:0]                     mem_rd_addr;
  logic [IDX_W-1:0]                     tw_idx;
  logic signed [ddft_pkg::SAMPLE_W-1:0] rd_sample;
  logic signed [ddft_pkg::TW_W-1:0]     tw_cos;
  logic signed [ddft_pkg::TW_W-1:0]     tw_sin;
  ddft_pkg::mac_tag_t                   mac_tag;
  logic                                 mac_done;
  logic signed [ddft_pkg::ACC_W-1:0]    acc_re;
  logic signed [ddft_pkg::ACC_W-1:0]    acc_im;
  logic signed [ddft_pkg::ACC_W-1:0]    re_rnd;
  logic signed [ddft_pkg::ACC_W-1:0]    im_rnd;
  logic [IDX_W-1:0]                     bin_k;
  logic                                 last_bin;
  logic signed [ddft_pkg::OUT_W-1:0]    bin_real_r;
  logic signed [ddft_pkg::OUT_W-1:0]    bin_imag_r;

  ddft_ctrl #(.POINTS(POINTS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .mem_we      (mem_we),
    .mem_wr_addr (mem_wr_addr),
    .mem_rd_addr (mem_rd_addr),
    .tw_idx      (tw_idx),
    .mac_tag     (mac_tag),
    .mac_done    (mac_done),
    .bin_k       (bin_k),
    .last_bin    (last_bin)
  );

  ddft_sample_mem #(.POINTS(POINTS)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (in_sample),
    .rd_addr (mem_rd_addr),
    .rd_data (rd_sample)
  );

  ddft_twiddle_rom #(.POINTS(POINTS)) u_rom (
    .clk    (clk),
    .tw_idx (tw_idx),
    .tw_cos (tw_cos),
    .tw_sin (tw_sin)
  );

  ddft_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_in (mac_tag),
    .smp    (rd_sample),
    .tw_cos (tw_cos),
    .tw_sin (tw_sin),
    .acc_re (acc_re),
    .acc_im (acc_im),
    .done   (mac_done)
  );

  // Round half up, then drop the 15 fraction bits
  assign re_rnd = acc_re + RND_HALF;
  assign im_rnd = acc_im + RND_HALF;

  // Capture the finished bin into the output register
  always_ff @(posedge clk) begin
    if (mac_done) begin
      bin_real_r <= re_rnd[ddft_pkg::RND_SHIFT + ddft_pkg::OUT_W - 1:ddft_pkg::RND_SHIFT];
      bin_imag_r <= im_rnd[ddft_pkg::RND_SHIFT + ddft_pkg::OUT_W - 1:ddft_pkg::RND_SHIFT];
    end
  end

  assign out_bin_index = ddft_pkg::BIN_W'(bin_k);
  assign out_bin_real  = bin_real_r;
  assign out_bin_imag  = bin_imag_r;
  assign out_last_bin  = last_bin;

endmodule
